@@ rtl/sha1_pkg.sv @@
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types, constants and control bundles for the SHA-1 hash engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned NumWords  = 16;
  localparam int unsigned NumHash   = 5;
  localparam int unsigned NumRounds = 80;
  localparam int unsigned NumBytes  = 64;
  localparam int unsigned RoundW    = 7;
  localparam int unsigned FillW     = 6;
  localparam int unsigned CountW    = 61;
  localparam int unsigned LenW      = 64;

  typedef logic [WordW-1:0]              word_t;
  typedef logic [NumHash-1:0][WordW-1:0] hash_t;

  localparam hash_t InitHash = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                                32'hefcdab89, 32'h67452301};
  localparam logic [3:0][WordW-1:0] RoundK = {32'hca62c1d6, 32'h8f1bbcdc,
                                              32'h6ed9eba1, 32'h5a827999};

  localparam logic [7:0]        PadByte   = 8'h80;
  localparam logic [FillW-1:0]  PadLimit  = FillW'(56);
  localparam logic [FillW-1:0]  LastFill  = FillW'(NumBytes - 1);
  localparam logic [RoundW-1:0] LastRound = RoundW'(NumRounds - 1);
  localparam logic [RoundW-1:0] Phase1Start = RoundW'(20);
  localparam logic [RoundW-1:0] Phase2Start = RoundW'(40);
  localparam logic [RoundW-1:0] Phase3Start = RoundW'(60);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } sha1_in_t;

  typedef struct packed {
    logic [WordW-1:0] digest_word0;
    logic [WordW-1:0] digest_word1;
    logic [WordW-1:0] digest_word2;
    logic [WordW-1:0] digest_word3;
    logic [WordW-1:0] digest_word4;
  } sha1_out_t;

  // Message schedule controls
  typedef struct packed {
    logic              byte_we;
    logic              pad_we;
    logic              len_we;
    logic              shift_en;
    logic [7:0]        data;
    logic [FillW-1:0]  fill;
    logic [LenW-1:0]   bit_len;
  } sched_ctrl_t;

  // Round unit controls
  typedef struct packed {
    logic              load_en;
    logic              round_en;
    logic [RoundW-1:0] idx;
  } round_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/sha1_sched.sv @@
// ----------------------------------------------------------------------------
// sha1_sched
// Block buffer and message schedule: packs bytes, pads, shifts out W[t].
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_sched (
  input  wire                        clk_i,
  input  wire sha1_pkg::sched_ctrl_t ctrl_i,
  output sha1_pkg::word_t            w_o
);
  import sha1_pkg::*;

  word_t w_q [NumWords];
  word_t w_d [NumWords];
  word_t w_next;

  // W[t+16] from the current window, w_q[0] holds W[t]
  assign w_next = {w_q[13][WordW-1:0] ^ w_q[8] ^ w_q[2] ^ w_q[0]};

  always_comb begin
    for (int i = 0; i < NumWords; i++) begin
      w_d[i] = w_q[i];
    end
    priority if (ctrl_i.shift_en) begin
      for (int i = 0; i < NumWords - 1; i++) begin
        w_d[i] = w_q[i + 1];
      end
      w_d[NumWords-1] = {w_next[WordW-2:0], w_next[WordW-1]};
    end else if (ctrl_i.byte_we) begin
      for (int i = 0; i < NumWords; i++) begin
        for (int j = 0; j < 4; j++) begin
          if (ctrl_i.fill == FillW'(i * 4 + j)) begin
            w_d[i][8*(3-j) +: 8] = ctrl_i.data;
          end
        end
      end
    end else if (ctrl_i.pad_we) begin
      // keep message bytes, mark the end, clear the rest
      for (int i = 0; i < NumWords; i++) begin
        for (int j = 0; j < 4; j++) begin
          if (ctrl_i.fill == FillW'(i * 4 + j)) begin
            w_d[i][8*(3-j) +: 8] = PadByte;
          end else if (ctrl_i.fill < FillW'(i * 4 + j)) begin
            w_d[i][8*(3-j) +: 8] = 8'h00;
          end
        end
      end
      if (ctrl_i.fill < PadLimit) begin
        w_d[NumWords-2] = ctrl_i.bit_len[LenW-1:WordW];
        w_d[NumWords-1] = ctrl_i.bit_len[WordW-1:0];
      end
    end else if (ctrl_i.len_we) begin
      // extra block: zeros and the length only
      for (int i = 0; i < NumWords - 2; i++) begin
        w_d[i] = '0;
      end
      w_d[NumWords-2] = ctrl_i.bit_len[LenW-1:WordW];
      w_d[NumWords-1] = ctrl_i.bit_len[WordW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumWords; i++) begin
      w_q[i] <= w_d[i];
    end
  end

  assign w_o = w_q[0];

endmodule

`default_nettype wire

@@ rtl/sha1_round.sv @@
// ----------------------------------------------------------------------------
// sha1_round
// Shared round unit: working registers a..e, one SHA-1 round per cycle while round_en is set.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_round (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire sha1_pkg::round_ctrl_t ctrl_i,
  input  wire sha1_pkg::hash_t       load_i,
  input  wire sha1_pkg::word_t       w_i,
  output sha1_pkg::hash_t            work_o
);
  import sha1_pkg::*;

  typedef enum logic [1:0] {
    PH_CH   = 2'd0,
    PH_PAR1 = 2'd1,
    PH_MAJ  = 2'd2,
    PH_PAR2 = 2'd3
  } phase_e;

  hash_t  work_q, work_d;
  phase_e phase;
  word_t  a, b, c, d, e;
  word_t  f, t;

  assign a = work_q[0];
  assign b = work_q[1];
  assign c = work_q[2];
  assign d = work_q[3];
  assign e = work_q[4];

  always_comb begin
    priority if (ctrl_i.idx < Phase1Start) begin
      phase = PH_CH;
    end else if (ctrl_i.idx < Phase2Start) begin
      phase = PH_PAR1;
    end else if (ctrl_i.idx < Phase3Start) begin
      phase = PH_MAJ;
    end else begin
      phase = PH_PAR2;
    end
  end

  always_comb begin
    unique case (phase)
      PH_CH:   f = (b & c) | (~b & d);
      PH_MAJ:  f = (b & c) | (b & d) | (c & d);
      PH_PAR1,
      PH_PAR2: f = b ^ c ^ d;
      default: f = b ^ c ^ d;
    endcase
  end

  assign t = {a[WordW-6:0], a[WordW-1:WordW-5]} + f + e + w_i + RoundK[phase];

  always_comb begin
    work_d = work_q;
    priority if (ctrl_i.load_en) begin
      work_d = load_i;
    end else if (ctrl_i.round_en) begin
      work_d[0] = t;
      work_d[1] = a;
      work_d[2] = {b[1:0], b[WordW-1:2]};
      work_d[3] = c;
      work_d[4] = d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q <= '0;
    end else begin
      work_q <= work_d;
    end
  end

  assign work_o = work_q;

endmodule

`default_nettype wire

@@ rtl/sha1_hash_engine_top.sv @@
// ----------------------------------------------------------------------------
// sha1_hash_engine_top
// Streaming SHA-1: byte input, five-word digest at the end of each message.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o | in_data_i  (sha1_in_t)
//  out     | output    | out_valid_o/ out_stall_i| out_data_o (sha1_out_t)
//
//  A byte that does not complete a block is written into the block buffer.
//  A completed block loads the round unit, runs the 80-round loop of the
//  shared round unit, one round per cycle, and then updates the chain.
//  A last transaction adds pad, 80 rounds, update and output steps; another
//  80 rounds and an update run when the length spills into an extra block.
//  Reset restores the initial chaining value; no clearing pass is needed.
//  The output register holds a digest while out_stall_i is high; input is
//  taken again as soon as the digest sits in that register.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_hash_engine_top (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_stall_o,
  input  wire sha1_pkg::sha1_in_t  in_data_i,
  output logic                     out_valid_o,
  input  wire                      out_stall_i,
  output sha1_pkg::sha1_out_t      out_data_o
);
  import sha1_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_PAD    = 5'b00010,
    S_ROUND  = 5'b00100,
    S_UPDATE = 5'b01000,
    S_EMIT   = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  hash_t              chain_q, chain_d;
  hash_t              sum;
  hash_t              work;
  logic [FillW-1:0]   fill_q, fill_d;
  logic [CountW-1:0]  count_q, count_d;
  logic [RoundW-1:0]  round_q, round_d;
  logic               final_q, final_d;
  logic               fin_pend_q, fin_pend_d;
  logic               len_pend_q, len_pend_d;
  logic               out_valid_q, out_valid_d;
  sha1_out_t          out_q;
  logic               out_load;
  logic               in_acc;
  word_t              w_cur;
  sched_ctrl_t        sched_ctrl;
  round_ctrl_t        round_ctrl;
  hash_t              load_val;

  assign in_acc = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    for (int i = 0; i < NumHash; i++) begin
      sum[i] = chain_q[i] + work[i];
    end
  end

  assign load_val = (state_q == S_UPDATE) ? sum : chain_q;

  always_comb begin
    state_d    = state_q;
    chain_d    = chain_q;
    fill_d     = fill_q;
    count_d    = count_q;
    round_d    = round_q;
    final_d    = final_q;
    fin_pend_d = fin_pend_q;
    len_pend_d = len_pend_q;
    out_load   = 1'b0;

    sched_ctrl          = '0;
    sched_ctrl.data     = in_data_i.data_byte;
    sched_ctrl.fill     = fill_q;
    sched_ctrl.bit_len  = {count_q, 3'b000};
    round_ctrl          = '0;
    round_ctrl.idx      = round_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data_i.has_byte) begin
            sched_ctrl.byte_we = 1'b1;
            fill_d  = fill_q + FillW'(1);
            count_d = count_q + CountW'(1);
            if (fill_q == LastFill) begin
              // block full: compress, finish afterwards if last
              round_ctrl.load_en = 1'b1;
              round_d    = '0;
              fin_pend_d = in_data_i.last;
              state_d    = S_ROUND;
            end else if (in_data_i.last) begin
              state_d = S_PAD;
            end
          end else if (in_data_i.last) begin
            state_d = S_PAD;
          end
        end
      end
      S_PAD: begin
        sched_ctrl.pad_we  = 1'b1;
        round_ctrl.load_en = 1'b1;
        round_d    = '0;
        final_d    = 1'b1;
        fin_pend_d = 1'b0;
        len_pend_d = (fill_q >= PadLimit);
        state_d    = S_ROUND;
      end
      S_ROUND: begin
        round_ctrl.round_en = 1'b1;
        sched_ctrl.shift_en = 1'b1;
        round_d = round_q + RoundW'(1);
        if (round_q == LastRound) begin
          round_d = '0;
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        chain_d = sum;
        priority if (len_pend_q) begin
          // length did not fit: run one more block
          sched_ctrl.len_we  = 1'b1;
          round_ctrl.load_en = 1'b1;
          len_pend_d = 1'b0;
          state_d    = S_ROUND;
        end else if (fin_pend_q) begin
          state_d = S_PAD;
        end else if (final_q) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          chain_d  = InitHash;
          fill_d   = '0;
          count_d  = '0;
          final_d  = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      chain_q     <= InitHash;
      fill_q      <= '0;
      count_q     <= '0;
      round_q     <= '0;
      final_q     <= 1'b0;
      fin_pend_q  <= 1'b0;
      len_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chain_q     <= chain_d;
      fill_q      <= fill_d;
      count_q     <= count_d;
      round_q     <= round_d;
      final_q     <= final_d;
      fin_pend_q  <= fin_pend_d;
      len_pend_q  <= len_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // hold the digest until the transaction completes
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.digest_word0 <= chain_q[0];
      out_q.digest_word1 <= chain_q[1];
      out_q.digest_word2 <= chain_q[2];
      out_q.digest_word3 <= chain_q[3];
      out_q.digest_word4 <= chain_q[4];
    end
  end

  sha1_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .w_o    (w_cur)
  );

  sha1_round u_round (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (round_ctrl),
    .load_i (load_val),
    .w_i    (w_cur),
    .work_o (work)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_round_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    round_q <= LastRound)
    else $error("round counter out of range");

  a_out_from_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_EMIT))
    else $error("digest presented outside the output step");

  a_last_stalls : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.last) |=> in_stall_o)
    else $error("input taken while a message is being finished");

  a_round_only_in_loop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (round_q != '0) |-> (state_q == S_ROUND))
    else $error("round counter running outside the round loop");

endmodule

`default_nettype wire

@@ dv/sha1_hash_engine_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha1_hash_engine_top_test
// Byte-stream SHA-1 regression. A local SHA-1 predictor follows every accepted
// input transaction and queues the digest each finished message must produce.
// The output monitor checks digests in order. Random sender bursts and
// receiver stalls run throughout.
// ----------------------------------------------------------------------------

module sha1_hash_engine_top_test;

  import sha1_pkg::sha1_in_t;
  import sha1_pkg::sha1_out_t;

  localparam int unsigned IdleLimit   = 3000;
  localparam int unsigned MaxReported = 10;
  localparam logic [7:0]  PadMark     = 8'h80;

  localparam logic [31:0] StartH [5] = '{32'h67452301, 32'hefcdab89, 32'h98badcfe,
                                         32'h10325476, 32'hc3d2e1f0};
  localparam logic [31:0] StepK  [4] = '{32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc,
                                         32'hca62c1d6};

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  sha1_in_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  sha1_out_t out_data_o;

  // predictor state
  logic [31:0] chain_h   [5];
  logic [7:0]  blk_bytes [64];
  logic [5:0]  fill_pos;
  logic [60:0] msg_bytes;
  sha1_out_t   pending_digests [$];

  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  int unsigned burst_left     = 0;
  int unsigned stall_left     = 0;
  int unsigned stall_mode     = 0;

  sha1_hash_engine_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // SHA-1 predictor
  // --------------------------------------------------------------------------
  function automatic void sha1_restart();
    for (int i = 0; i < 5; i++) chain_h[i] = StartH[i];
    fill_pos  = '0;
    msg_bytes = '0;
  endfunction

  function automatic void sha1_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t, wr;
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    end
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        wr = w[r];
      end else begin
        wr = w[(r + 13) & 15] ^ w[(r + 8) & 15] ^ w[(r + 2) & 15] ^ w[r & 15];
        wr = {wr[30:0], wr[31]};
        w[r & 15] = wr;
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = StepK[0];
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = StepK[1];
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = StepK[2];
      end else begin
        f = b ^ c ^ d;
        k = StepK[3];
      end
      t = {a[26:0], a[31:27]} + f + e + wr + k;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  // Absorb one accepted transaction; queue a digest when the message ends.
  function automatic void sha1_absorb(sha1_in_t item);
    int          pos;
    logic [63:0] bit_len;
    sha1_out_t   dig;
    if (item.has_byte) begin
      blk_bytes[fill_pos] = item.data_byte;
      fill_pos  = fill_pos + 6'd1;
      msg_bytes = msg_bytes + 61'd1;
      if (fill_pos == '0) sha1_compress();
    end
    if (!item.last) return;
    pos = fill_pos;
    blk_bytes[pos] = PadMark;
    pos++;
    // no room for the length: flush this block, length goes in a fresh one
    if (pos > 56) begin
      while (pos < 64) begin
        blk_bytes[pos] = 8'h00;
        pos++;
      end
      sha1_compress();
      pos = 0;
    end
    while (pos < 56) begin
      blk_bytes[pos] = 8'h00;
      pos++;
    end
    bit_len = {msg_bytes, 3'b000};
    for (int i = 0; i < 8; i++) blk_bytes[56 + i] = bit_len[63 - 8*i -: 8];
    sha1_compress();
    dig.digest_word0 = chain_h[0];
    dig.digest_word1 = chain_h[1];
    dig.digest_word2 = chain_h[2];
    dig.digest_word3 = chain_h[3];
    dig.digest_word4 = chain_h[4];
    pending_digests.push_back(dig);
    sha1_restart();
  endfunction

  function automatic logic [31:0] digest_field(sha1_out_t dig, int idx);
    case (idx)
      0:       return dig.digest_word0;
      1:       return dig.digest_word1;
      2:       return dig.digest_word2;
      3:       return dig.digest_word3;
      default: return dig.digest_word4;
    endcase
  endfunction

  function automatic sha1_in_t make_item(logic [7:0] data, logic has, logic fin);
    sha1_in_t item;
    item.data_byte = data;
    item.has_byte  = has;
    item.last      = fin;
    return item;
  endfunction

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  task automatic send_item(sha1_in_t item);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 300)
                                               : $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    sha1_absorb(item);
  endtask

  // Random bytes; end either on the last byte or with an empty last transaction.
  task automatic send_message(int len, bit empty_end, int noise_pct);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_item(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b0));
      end
      send_item(make_item(8'($urandom_range(0, 255)), 1'b1,
                          (i == len - 1) && !empty_end));
    end
    if (empty_end || len == 0) send_item(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b1));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed_edges();
    send_item(make_item(8'h00, 1'b0, 1'b1));   // empty message
    send_item(make_item(8'h00, 1'b1, 1'b1));   // byte with last
    send_item(make_item(8'hff, 1'b1, 1'b1));
    send_item(make_item(8'hff, 1'b0, 1'b0));   // no byte: nothing changes
    send_item(make_item(8'h00, 1'b0, 1'b0));
    send_item(make_item(8'ha5, 1'b1, 1'b0));
    send_item(make_item(8'h5a, 1'b0, 1'b0));
    send_item(make_item(8'h5a, 1'b1, 1'b1));
    send_item(make_item(8'hff, 1'b1, 1'b0));
    send_item(make_item(8'h00, 1'b1, 1'b0));
    send_item(make_item(8'hff, 1'b0, 1'b1));   // empty last after bytes
    send_item(make_item(8'h00, 1'b0, 1'b0));
    send_item(make_item(8'hff, 1'b0, 1'b1));   // empty again, after idle item
  endtask

  // Lengths around the pad spill point and block edges.
  task automatic test_block_boundaries();
    int lens [12] = '{55, 55, 56, 56, 57, 63, 63, 64, 64, 65, 119, 128};
    for (int i = 0; i < 12; i++) send_message(lens[i], i[0], 0);
  endtask

  task automatic test_random_stream();
    int items;
    int len;
    bit empty_end;
    items = 0;
    while (items < 620) begin
      case ($urandom_range(0, 9))
        0:       len = $urandom_range(100, 200);
        1, 2:    len = $urandom_range(52, 70);
        default: len = $urandom_range(0, 40);
      endcase
      empty_end = ($urandom_range(0, 3) == 0);
      send_message(len, empty_end, 5);
      items += len + ((empty_end || len == 0) ? 1 : 0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver stall pattern, digest checker, watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 15) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    sha1_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_digests.size() == 0) begin
        if (mismatch_count < MaxReported) begin
          $display("%0t: digest with none expected: %h", $realtime, out_data_o);
        end
        mismatch_count++;
      end else begin
        want = pending_digests.pop_front();
        for (int i = 0; i < 5; i++) begin
          if (digest_field(out_data_o, i) !== digest_field(want, i)) begin
            if (mismatch_count < MaxReported) begin
              $display("%0t: digest_word%0d expected %h actual %h", $realtime, i,
                       digest_field(want, i), digest_field(out_data_o, i));
            end
            mismatch_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sha1_restart();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_edges();
    test_block_boundaries();
    test_random_stream();
    in_valid_i <= 1'b0;
    while (pending_digests.size() != 0) @(posedge clk_i);
    // catch any stray digest
    repeat (400) @(posedge clk_i);
    if (mismatch_count == 0 && pending_digests.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/sha1_pkg.sv
rtl/sha1_sched.sv
rtl/sha1_round.sv
rtl/sha1_hash_engine_top.sv
dv/sha1_hash_engine_top_test.sv
